// ===== design/fsla_pkg.sv =====
`default_nettype none

package fsla_pkg;

  // Field widths fixed by the request and result formats
  localparam int SLOT_W  = 8;
  localparam int COUNT_W = 9;
  localparam int STAT_W  = 2;

  // Request codes
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

  // Controller states: idle/accepting, or waiting on a link read for a pop
  typedef enum logic {
    ST_IDLE,
    ST_POP
  } state_t;

  // Link memory access, one write and one read port
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [SLOT_W-1:0] wdata;
    logic              re;
    logic [SLOT_W-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

// ===== design/fsla_ifs.sv =====
`default_nettype none

// Request channel
interface fsla_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] slot_index;

  modport source (output valid, output req_type, output slot_index, input ready);
  modport sink   (input valid, input req_type, input slot_index, output ready);
endinterface

// Result channel
interface fsla_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] granted_slot;
  logic [1:0] status;
  logic [8:0] free_count;

  modport source (output valid, output granted_slot, output status, output free_count,
                  input ready);
  modport sink   (input valid, input granted_slot, input status, input free_count,
                  output ready);
endinterface

`default_nettype wire

// ===== design/fsla_link_mem.sv =====
`default_nettype none

module fsla_link_mem #(
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire fsla_pkg::mem_req_t       req,
  output logic [fsla_pkg::SLOT_W-1:0]   rdata
);
  import fsla_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [SLOT_W-1:0] mem [DEPTH];
  logic [SLOT_W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr[AW-1:0]];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== design/fsla_ctrl.sv =====
`default_nettype none

module fsla_ctrl #(
  parameter int MAX_SLOTS  = 256,
  parameter int LINK_DEPTH = 256
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  fsla_in_if.sink                        in_chan,
  fsla_out_if.source                     out_chan,
  input  wire logic                      cfg_we,
  input  wire logic [fsla_pkg::COUNT_W-1:0] cfg_wdata,
  output fsla_pkg::mem_req_t             mem_req,
  input  wire logic [fsla_pkg::SLOT_W-1:0] mem_rdata
);
  import fsla_pkg::*;

  // Largest pool size the count registers can hold
  localparam int COUNT_MAX  = (1 << COUNT_W) - 1;
  localparam int POOL_CAP   = (MAX_SLOTS < COUNT_MAX) ? MAX_SLOTS : COUNT_MAX;
  localparam int RESET_POOL = (POOL_CAP < 256) ? POOL_CAP : 256;

  state_t             state_r, state_nxt;
  logic [COUNT_W-1:0] pool_slots_r, pool_slots_nxt;
  logic [COUNT_W-1:0] free_slots_r, free_slots_nxt;
  logic [COUNT_W-1:0] fresh_count_r, fresh_count_nxt;
  logic [SLOT_W-1:0]  list_head_r, list_head_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0]  out_slot_r, out_slot_nxt;
  logic [STAT_W-1:0]  out_status_r, out_status_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;

  logic               out_free;
  logic               accept;
  logic               pool_empty;
  logic               pool_full;
  logic               fresh_hit;
  logic               slot_in_range;
  logic               head_in_range;
  logic [COUNT_W-1:0] fresh_inc;
  logic [COUNT_W-1:0] cfg_pool;

  // Status of the pool
  assign out_free      = !out_valid_r || out_chan.ready;
  // take a beat only when idle, the result slot frees up and no resize is under way
  assign in_chan.ready = (state_r == ST_IDLE) && out_free && !cfg_we;
  assign accept        = in_chan.valid && in_chan.ready;
  assign pool_empty    = (free_slots_r == '0);
  assign pool_full     = (free_slots_r >= pool_slots_r);
  assign fresh_hit     = (fresh_count_r == (pool_slots_r - free_slots_r));
  assign slot_in_range = ({1'b0, in_chan.slot_index} < COUNT_W'(LINK_DEPTH));
  assign head_in_range = ({1'b0, list_head_r} < COUNT_W'(LINK_DEPTH));
  assign fresh_inc     = fresh_count_r + COUNT_W'(1);

  // Pool size clamp on configuration writes
  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_pool = COUNT_W'(1);
    end else if (cfg_wdata > COUNT_W'(POOL_CAP)) begin
      cfg_pool = COUNT_W'(POOL_CAP);
    end else begin
      cfg_pool = cfg_wdata;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!cfg_we && accept && (in_chan.req_type == REQ_ALLOC) && !pool_empty
            && !fresh_hit) begin
          state_nxt = ST_POP;
        end
      end
      ST_POP: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath, memory accesses and result register
  always_comb begin
    pool_slots_nxt  = pool_slots_r;
    free_slots_nxt  = free_slots_r;
    fresh_count_nxt = fresh_count_r;
    list_head_nxt   = list_head_r;
    out_slot_nxt    = out_slot_r;
    out_status_nxt  = out_status_r;
    out_count_nxt   = out_count_r;
    out_valid_nxt   = out_valid_r && !out_chan.ready;
    mem_req.we      = 1'b0;
    mem_req.waddr   = in_chan.slot_index;
    mem_req.wdata   = list_head_r;
    mem_req.re      = 1'b0;
    mem_req.raddr   = list_head_r;

    case (state_r)
      ST_IDLE: begin
        if (cfg_we) begin
          // rebuild the pool
          pool_slots_nxt  = cfg_pool;
          free_slots_nxt  = cfg_pool;
          fresh_count_nxt = '0;
          list_head_nxt   = '0;
        end else if (accept) begin
          if (in_chan.req_type == REQ_ALLOC) begin
            if (pool_empty) begin
              out_valid_nxt  = 1'b1;
              out_slot_nxt   = '0;
              out_status_nxt = STATUS_EMPTY;
              out_count_nxt  = free_slots_r;
            end else if (fresh_hit) begin
              // hand out the next never-used slot
              fresh_count_nxt = fresh_inc;
              list_head_nxt   = fresh_inc[SLOT_W-1:0];
              free_slots_nxt  = free_slots_r - COUNT_W'(1);
              out_valid_nxt   = 1'b1;
              out_slot_nxt    = fresh_count_r[SLOT_W-1:0];
              out_status_nxt  = STATUS_OK;
              out_count_nxt   = free_slots_r - COUNT_W'(1);
            end else begin
              // pop: fetch the head's link, finish next cycle
              mem_req.re = head_in_range;
            end
          end else begin
            if (pool_full) begin
              out_valid_nxt  = 1'b1;
              out_slot_nxt   = '0;
              out_status_nxt = STATUS_FULL;
              out_count_nxt  = free_slots_r;
            end else begin
              // push onto the list head
              mem_req.we     = slot_in_range;
              list_head_nxt  = in_chan.slot_index;
              free_slots_nxt = free_slots_r + COUNT_W'(1);
              out_valid_nxt  = 1'b1;
              out_slot_nxt   = '0;
              out_status_nxt = STATUS_OK;
              out_count_nxt  = free_slots_r + COUNT_W'(1);
            end
          end
        end
      end
      ST_POP: begin
        // result register was emptied at the accept edge
        list_head_nxt  = head_in_range ? mem_rdata : '0;
        free_slots_nxt = free_slots_r - COUNT_W'(1);
        out_valid_nxt  = 1'b1;
        out_slot_nxt   = list_head_r;
        out_status_nxt = STATUS_OK;
        out_count_nxt  = free_slots_r - COUNT_W'(1);
      end
      default: begin
        // hold everything
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      pool_slots_r  <= COUNT_W'(RESET_POOL);
      free_slots_r  <= COUNT_W'(RESET_POOL);
      fresh_count_r <= '0;
      list_head_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      pool_slots_r  <= pool_slots_nxt;
      free_slots_r  <= free_slots_nxt;
      fresh_count_r <= fresh_count_nxt;
      list_head_r   <= list_head_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_slot_r   <= out_slot_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.granted_slot = out_slot_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.free_count   = out_count_r;

endmodule

`default_nettype wire

// ===== design/fixed_slot_free_list_allocator.sv =====
// Channel  | Dir | Handshake        | Beat contents
// in_chan  | in  | valid/ready      | req_type, slot_index
// out_chan | out | valid/ready      | granted_slot, status, free_count
// cfg      | in  | cfg_we           | cfg_wdata = pool_slots
//
// Allocate from fresh slots, frees and failed requests: the result is
// registered from the beat. Allocate popping the free list: ST_POP waits
// on the link memory's registered read of the head's next link.
// Reset (rst_n low, sync) gives min(MAX_SLOTS, 256) slots, all fresh.
// A result waits in the output register; a new beat is taken in that
// cycle whenever out_chan.ready drains it, if idle and cfg_we is low.
`default_nettype none

module fixed_slot_free_list_allocator #(
  parameter int MAX_SLOTS = 256
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  fsla_in_if.sink                           in_chan,
  fsla_out_if.source                        out_chan,
  input  wire logic                         cfg_we,
  input  wire logic [fsla_pkg::COUNT_W-1:0] cfg_wdata
);
  import fsla_pkg::*;

  // Links only exist for indices a slot field can name
  localparam int LINK_DEPTH = (MAX_SLOTS < (1 << SLOT_W)) ? MAX_SLOTS : (1 << SLOT_W);

  mem_req_t          mem_req;
  logic [SLOT_W-1:0] mem_rdata;

  fsla_ctrl #(
    .MAX_SLOTS  (MAX_SLOTS),
    .LINK_DEPTH (LINK_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  fsla_link_mem #(
    .DEPTH (LINK_DEPTH)
  ) u_link_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

// ===== design/fsla_checker.sv =====
`default_nettype none

module fsla_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_granted_slot,
  input wire logic [1:0] out_status,
  input wire logic [8:0] out_free_count
);
  import fsla_pkg::*;

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_granted_slot)
      && $stable(out_status) && $stable(out_free_count))
    else $error("result beat changed while stalled");

  // Reset leaves no result pending
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Empty pool reports no slot and no free count
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_EMPTY |-> out_free_count == '0
      && out_granted_slot == '0)
    else $error("empty-pool result inconsistent");

  // Rejected free grants nothing and leaves a nonzero count
  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_FULL |-> out_granted_slot == '0
      && out_free_count != '0)
    else $error("full-pool result inconsistent");

endmodule

bind fixed_slot_free_list_allocator fsla_checker u_fsla_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_granted_slot (out_chan.granted_slot),
  .out_status       (out_chan.status),
  .out_free_count   (out_chan.free_count)
);

`default_nettype wire
